### rtl/sia_pkg.sv
// Package with types, codes and parameters shared by the integer ALU modules.
package sia_pkg;

    localparam int unsigned DataWidth   = 64;
    localparam int unsigned QueueDepth  = 4;
    localparam int unsigned DivPipe     = 64;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_XOR  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SHR  = 4'd9,
        OP_NEG  = 4'd10,
        OP_NOT  = 4'd11
    } op_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic               divide_by_zero;
    } out_word_t;

    // Operation class decided by the front end.
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic               want_mod;
        logic               zero_div;
        logic               min_neg1;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0]        simple;
    } cmd_t;

endpackage

### rtl/script_integer_alu.sv
// Top level of the 64-bit script-language integer ALU.
// Path: an accepted word passes the queue, one prepare stage and 64 divide stages;
//   the output register loads last.
// Throughput: one word per cycle unless the output stalls; the 64-stage bit-per-stage divider sets latency.
// The back pipe holds as a whole while a full output register stalls with a word at the pipe's end;
// a 4-entry queue absorbs input. Reset: asynchronous active-low rst_n clears all valid and pointer state.
module script_integer_alu #(
    parameter int unsigned QueueDepth = sia_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sia_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sia_pkg::out_word_t out_data
);
    sia_pkg::cmd_t      cmd_f, cmd_q;
    logic               full, empty, pop, adv, pv;
    sia_pkg::out_word_t pw;
    logic               ov_reg, ov_next;
    sia_pkg::out_word_t od_reg;

    sia_front u_front (.in_word(in_data), .cmd(cmd_f));

    assign in_stall = full;

    sia_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid && !full), .push_data(cmd_f), .full(full),
        .pop(pop), .pop_data(cmd_q), .empty(empty)
    );

    // Pipe moves when the output register can take what leaves it.
    assign adv = !ov_reg || !out_stall || !pv;
    assign pop = adv && !empty;

    sia_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(!empty), .cmd(cmd_q),
        .adv(adv), .out_valid(pv), .out_word(pw)
    );

    always_comb
    begin
        ov_next = ov_reg;
        if (!ov_reg || !out_stall)
            ov_next = pv && adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        if ((!ov_reg || !out_stall) && pv)
            od_reg <= pw;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");
    no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        pv && !adv |-> ov_reg && out_stall)
        else $error("pipe held without cause");
endmodule

### rtl/sia_front.sv
// Front end: classifies each word and computes the simple operations combinationally.
module sia_front (
    input  sia_pkg::in_word_t in_word,
    output sia_pkg::cmd_t     cmd
);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] lsh;
    logic [63:0] rsh;
    logic        big;
    logic [5:0]  amt;
    logic [63:0] simple;

    assign ua = in_word.operand_a;
    assign ub = in_word.operand_b;
    // A count is out of range at 64 and above or at -64 and below.
    assign big = ub[63] ? (ub < 64'hFFFF_FFFF_FFFF_FFC1) : (ub > 64'd63);
    assign amt = ub[63] ? 6'(64'd0 - ub) : ub[5:0];
    assign lsh = ua << amt;
    assign rsh = ua >> amt;

    always_comb
    begin
        simple = 64'd0;
        case (in_word.operation)
            sia_pkg::OP_ADD: simple = ua + ub;
            sia_pkg::OP_SUB: simple = ua - ub;
            sia_pkg::OP_AND: simple = ua & ub;
            sia_pkg::OP_OR:  simple = ua | ub;
            sia_pkg::OP_XOR: simple = ua ^ ub;
            sia_pkg::OP_SHL: simple = big ? 64'd0 : (ub[63] ? rsh : lsh);
            sia_pkg::OP_SHR: simple = big ? 64'd0 : (ub[63] ? lsh : rsh);
            sia_pkg::OP_NEG: simple = 64'd0 - ua;
            sia_pkg::OP_NOT: simple = ~ua;
            default:         simple = 64'd0;
        endcase
    end

    always_comb
    begin
        cmd.cls      = sia_pkg::CLS_SIMPLE;
        if (in_word.operation == sia_pkg::OP_MUL)
            cmd.cls = sia_pkg::CLS_MUL;
        else if (in_word.operation == sia_pkg::OP_DIV || in_word.operation == sia_pkg::OP_MOD)
            cmd.cls = sia_pkg::CLS_DIV;
        cmd.want_mod = (in_word.operation == sia_pkg::OP_MOD);
        cmd.zero_div = (ub == 64'd0);
        cmd.min_neg1 = (ua == 64'h8000_0000_0000_0000) && (ub == '1);
        cmd.a        = in_word.operand_a;
        cmd.b        = in_word.operand_b;
        cmd.simple   = simple;
    end
endmodule

### rtl/sia_queue.sv
// Small FIFO between front end and back end.
module sia_queue #(
    parameter int unsigned Depth = sia_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sia_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output sia_pkg::cmd_t pop_data,
    output logic          empty
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    sia_pkg::cmd_t   mem_reg [Depth];
    logic [AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;

    assign full     = (cnt_reg == (AW+1)'(Depth));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(Depth))
        else $error("queue count overflow");
    no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("push into full queue");
    no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
endmodule

### rtl/sia_back.sv
// Back end: pipelined multiplier and restoring divider, one bit per stage; simple results ride along.
module sia_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sia_pkg::cmd_t     cmd,
    input  logic              adv,
    output logic              out_valid,
    output sia_pkg::out_word_t out_word
);
    localparam int unsigned Stages = sia_pkg::DivPipe;

    // Stage 0 prepares magnitudes; then Stages divide steps; then fix-up.
    typedef struct packed {
        sia_pkg::cls_t cls;
        logic          want_mod;
        logic          zero_div;
        logic          min_neg1;
        logic          neg_a;
        logic          neg_b;
        logic [63:0]   rem;
        logic [63:0]   quo;
        logic [63:0]   dvs;
        logic [63:0]   keep;
        logic [63:0]   bsigned;
    } stg_t;

    stg_t        st_reg [Stages+1];
    logic        v_reg  [Stages+1];
    stg_t        st_next [Stages+1];
    // Multiply partials: three 32x32 products, registered, then summed.
    logic [63:0] p_ll_reg, p_lh_reg, p_hl_reg;
    logic [63:0] mulres_reg [1:Stages];

    always_comb
    begin
        st_next[0].cls      = cmd.cls;
        st_next[0].want_mod = cmd.want_mod;
        st_next[0].zero_div = cmd.zero_div;
        st_next[0].min_neg1 = cmd.min_neg1;
        st_next[0].neg_a    = cmd.a[63];
        st_next[0].neg_b    = cmd.b[63];
        st_next[0].rem      = '0;
        st_next[0].quo      = cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
        st_next[0].dvs      = cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
        st_next[0].keep     = cmd.simple;
        st_next[0].bsigned  = cmd.b;
    end

    for (genvar i = 1; i <= Stages; i++)
    begin : g_div
        logic [64:0] sh;
        logic [64:0] df;
        always_comb
        begin
            sh = {st_reg[i-1].rem, st_reg[i-1].quo[63]};
            df = sh - {1'b0, st_reg[i-1].dvs};
            st_next[i] = st_reg[i-1];
            if (!df[64])
            begin
                st_next[i].rem = df[63:0];
                st_next[i].quo = {st_reg[i-1].quo[62:0], 1'b1};
            end
            else
            begin
                st_next[i].rem = sh[63:0];
                st_next[i].quo = {st_reg[i-1].quo[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Stages; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= Stages; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= st_next[0];
            p_ll_reg   <= cmd.a[31:0] * cmd.b[31:0];
            p_lh_reg   <= cmd.a[31:0] * cmd.b[63:32];
            p_hl_reg   <= cmd.a[63:32] * cmd.b[31:0];
            mulres_reg[1] <= p_ll_reg + {p_lh_reg[31:0] + p_hl_reg[31:0], 32'd0};
            for (int i = 1; i <= Stages; i++)
                st_reg[i] <= st_next[i];
            for (int i = 2; i <= Stages; i++)
                mulres_reg[i] <= mulres_reg[i-1];
        end
    end

    // Floor correction on the truncated magnitude results.
    stg_t        fin;
    logic [63:0] q_t, r_t, q_f, r_f;
    assign fin = st_reg[Stages];
    always_comb
    begin
        q_t = (fin.neg_a ^ fin.neg_b) ? 64'd0 - fin.quo : fin.quo;
        r_t = fin.neg_a ? 64'd0 - fin.rem : fin.rem;
        q_f = q_t;
        r_f = r_t;
        if (r_t != 64'd0 && (fin.neg_a != fin.neg_b))
        begin
            q_f = q_t - 64'd1;
            r_f = r_t + fin.bsigned;
        end
        out_word.divide_by_zero = 1'b0;
        case (fin.cls)
            sia_pkg::CLS_MUL: out_word.result = mulres_reg[Stages];
            sia_pkg::CLS_DIV:
            begin
                if (fin.zero_div)
                begin
                    out_word.result = '0;
                    out_word.divide_by_zero = 1'b1;
                end
                else if (fin.min_neg1)
                    out_word.result = fin.want_mod ? 64'd0 : 64'h8000_0000_0000_0000;
                else
                    out_word.result = fin.want_mod ? r_f : q_f;
            end
            default: out_word.result = fin.keep;
        endcase
    end
    assign out_valid = v_reg[Stages];

    dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.divide_by_zero |-> fin.cls == sia_pkg::CLS_DIV)
        else $error("divide flag on non-divide");
    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(out_valid))
        else $error("pipe moved while held");
    rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fin.cls == sia_pkg::CLS_DIV && !fin.zero_div |-> fin.rem < fin.dvs)
        else $error("remainder not below divisor");
endmodule
